FILE: design/gtg_pkg.sv
// Shared types, fixed-point constants and the tanh table for the GELU gradient unit.
// Depends on nothing; the interfaces and the top level import it.
package gtg_pkg;

  // Number format of every word: signed Q4.12.
  localparam int DATA_WIDTH    = 16;
  localparam int FRAC_BITS     = 12;
  localparam int TANH_SEGMENTS = 32;
  localparam int SEG_BITS      = $clog2(TANH_SEGMENTS);

  localparam int ONE        = 1 << FRAC_BITS;
  // Tanh saturates to one at |u| >= 4.0.
  localparam int TANH_LIMIT = 4 * ONE;
  // Guard band on the doubled derivative.
  localparam int D2_LIMIT   = 4 * ONE;
  // sqrt(2/pi) and 0.044715 rounded to Q4.12.
  localparam int BETA       = 3268;
  localparam int KAPPA      = 183;

  // Width of the fraction inside one tanh segment, and the shift from |u| to a segment.
  localparam int POS_FRAC   = FRAC_BITS + 2;
  localparam int SEG_SHIFT  = POS_FRAC - SEG_BITS;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [FRAC_BITS:0]           tanh_entry_t;
  typedef logic signed [39:0]           wide_t;

  // Entry k is tanh(4k/32) in unsigned Q1.12, rounded to nearest.
  localparam tanh_entry_t TANH_ROM [0:TANH_SEGMENTS] = '{
    13'd0,    13'd509,  13'd1003, 13'd1468, 13'd1893, 13'd2272, 13'd2602, 13'd2883,
    13'd3119, 13'd3315, 13'd3475, 13'd3604, 13'd3707, 13'd3790, 13'd3856, 13'd3908,
    13'd3949, 13'd3981, 13'd4006, 13'd4026, 13'd4041, 13'd4053, 13'd4063, 13'd4070,
    13'd4076, 13'd4080, 13'd4084, 13'd4086, 13'd4089, 13'd4090, 13'd4091, 13'd4092,
    13'd4093
  };

  // Arithmetic right shift that rounds to nearest with ties away from zero.
  // For negative values the bias is one less than half, which mirrors the positive case.
  function automatic wide_t round_shift(input wide_t v, input int unsigned sh);
    wide_t bias;
    bias = (wide_t'(1) <<< (sh - 1)) - ((v < 0) ? wide_t'(1) : wide_t'(0));
    return (v + bias) >>> sh;
  endfunction

endpackage

FILE: design/gtg_in_if.sv
// Input channel of the GELU gradient unit: one activation and one upstream gradient a word.
// Depends on gtg_pkg for the data type.
interface gtg_in_if;
  import gtg_pkg::*;

  logic  valid;
  logic  ready;
  data_t activation_input;
  data_t upstream_gradient;

  modport source(output valid, activation_input, upstream_gradient, input ready);
  modport sink(input valid, activation_input, upstream_gradient, output ready);
endinterface

FILE: design/gtg_out_if.sv
// Output channel of the GELU gradient unit: one input gradient a word.
// Depends on gtg_pkg for the data type.
interface gtg_out_if;
  import gtg_pkg::*;

  logic  valid;
  logic  ready;
  data_t input_gradient;

  modport source(output valid, input_gradient, input ready);
  modport sink(input valid, input_gradient, output ready);
endinterface

FILE: design/gelu_tanh_gradient_unit.sv
// Top level of the GELU (tanh approximation) gradient unit: an eleven-stage pipeline.
// Depends on gtg_pkg, gtg_in_if and gtg_out_if.
//
//   Channel  Direction  Payload                                   Handshake
//   din      in         activation_input, upstream_gradient (Q4.12) valid / ready
//   dout     out        input_gradient (Q4.12, saturated)         valid / ready
//
// One word can enter every cycle unless the pipeline is full and the output stalls.
// An accepted word moves through stages s0 to s10 and leaves from s10. Each stage
// holds about one multiply with its rounding, the tanh lookup or the derivative clamp.
// Reset (rst, synchronous) clears the stage valid bits; the data registers are not reset.
// Each stage holds its word only while the stage after it is full and held, so
// bubbles are squeezed out during an output stall and nothing is lost or repeated.
module gelu_tanh_gradient_unit (
  input logic     clk,
  input logic     rst,
  gtg_in_if.sink  din,
  gtg_out_if.source dout
);
  import gtg_pkg::*;

  localparam int STAGES = 11;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  // Stage registers.
  data_t              s0_x, s0_g;
  logic signed [19:0] s0_x2;
  data_t              s1_x, s1_g;
  logic signed [14:0] s1_kx2;
  data_t              s2_x, s2_g;
  logic signed [14:0] s2_kx2;
  logic signed [17:0] s2_p;
  data_t              s3_x, s3_g;
  logic signed [14:0] s3_kx2;
  logic signed [17:0] s3_u;
  data_t              s4_x, s4_g;
  logic signed [14:0] s4_kx2;
  logic signed [13:0] s4_t;
  data_t              s5_x, s5_g;
  logic signed [16:0] s5_f;
  logic signed [13:0] s5_t, s5_s;
  data_t              s6_g;
  logic signed [16:0] s6_f;
  logic signed [13:0] s6_t;
  logic signed [16:0] s6_a;
  data_t              s7_g;
  logic signed [16:0] s7_f;
  logic signed [13:0] s7_t;
  logic signed [15:0] s7_b;
  data_t              s8_g;
  logic signed [13:0] s8_t;
  logic signed [18:0] s8_c;
  data_t              s9_g;
  logic signed [15:0] s9_d2;
  data_t              s10_r;

  // Combinational values feeding each stage.
  wide_t              m0, m1, m2, m3, m5, m6, m7, m8, m10;
  wide_t              x2_w, kx2_w, xk_w, u_w, tt_w, a_w, b_w, c_w, r_w;
  logic signed [19:0] x2_next;
  logic signed [14:0] kx2_next;
  logic signed [17:0] p_next, u_next;
  logic signed [13:0] t_next, s_next;
  logic signed [16:0] f_next, a_next;
  logic signed [15:0] b_next, d2_next;
  logic signed [18:0] c_next;
  logic signed [19:0] d2_sum;
  data_t              r_next;

  logic [17:0]           u_mag;
  logic [SEG_BITS-1:0]   seg;
  logic [SEG_BITS:0]     idx_lo, idx_hi;
  logic [POS_FRAC-1:0]   seg_frac;
  tanh_entry_t           lo_val, hi_val, y_mag;
  logic [FRAC_BITS-3:0]  diff;
  logic [22:0]           interp_prod;
  logic [FRAC_BITS-3:0]  interp;

  // Stall chain: a stage may load when it is empty or its successor loads.
  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || dout.ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign din.ready  = en[0];
  assign dout.valid = vld[STAGES-1];
  assign dout.input_gradient = s10_r;

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= din.valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Square of x, then kappa x^2.
  always_comb begin
    m0       = wide_t'(din.activation_input) * wide_t'(din.activation_input);
    x2_w     = round_shift(m0, FRAC_BITS);
    x2_next  = x2_w[19:0];
    m1       = wide_t'(s0_x2) * wide_t'(KAPPA);
    kx2_w    = round_shift(m1, FRAC_BITS);
    kx2_next = kx2_w[14:0];
  end

  // Cubic argument p = x + x kappa x^2, then u = beta p.
  always_comb begin
    m2     = wide_t'(s1_x) * wide_t'(s1_kx2);
    xk_w   = round_shift(m2, FRAC_BITS);
    p_next = 18'(s1_x) + xk_w[17:0];
    m3     = wide_t'(s2_p) * wide_t'(BETA);
    u_w    = round_shift(m3, FRAC_BITS);
    u_next = u_w[17:0];
  end

  // Piecewise-linear tanh on |u|, mirrored for negative u.
  always_comb begin
    u_mag       = (s3_u < 0) ? 18'(-s3_u) : 18'(s3_u);
    seg         = u_mag[POS_FRAC-1:SEG_SHIFT];
    idx_lo      = {1'b0, seg};
    idx_hi      = idx_lo + 1'b1;
    seg_frac    = {u_mag[SEG_SHIFT-1:0], {SEG_BITS{1'b0}}};
    lo_val      = TANH_ROM[idx_lo];
    hi_val      = TANH_ROM[idx_hi];
    diff        = (FRAC_BITS-2)'(hi_val - lo_val);
    interp_prod = 23'(diff) * 23'(seg_frac);
    interp      = (FRAC_BITS-2)'((interp_prod + 23'(1 << (POS_FRAC - 1))) >> POS_FRAC);
    if (u_mag >= 18'(TANH_LIMIT)) begin
      y_mag = tanh_entry_t'(ONE);
    end else begin
      y_mag = lo_val + tanh_entry_t'(interp);
    end
    t_next = (s3_u < 0) ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
  end

  // s = 1 - t^2 and the factor 1 + 3 kappa x^2.
  always_comb begin
    m5     = wide_t'(s4_t) * wide_t'(s4_t);
    tt_w   = round_shift(m5, FRAC_BITS);
    s_next = 14'(ONE) - tt_w[13:0];
    f_next = 17'(ONE) + 17'(s4_kx2) + 17'(s4_kx2) + 17'(s4_kx2);
  end

  // a = x s, b = a beta, c = b f.
  always_comb begin
    m6     = wide_t'(s5_x) * wide_t'(s5_s);
    a_w    = round_shift(m6, FRAC_BITS);
    a_next = a_w[16:0];
    m7     = wide_t'(s6_a) * wide_t'(BETA);
    b_w    = round_shift(m7, FRAC_BITS);
    b_next = b_w[15:0];
    m8     = wide_t'(s7_b) * wide_t'(s7_f);
    c_w    = round_shift(m8, FRAC_BITS);
    c_next = c_w[18:0];
  end

  // Doubled derivative with its guard clamp.
  always_comb begin
    d2_sum = 20'(ONE) + 20'(s8_t) + 20'(s8_c);
    if (d2_sum > 20'(D2_LIMIT)) begin
      d2_next = 16'(D2_LIMIT);
    end else if (d2_sum < -20'(D2_LIMIT)) begin
      d2_next = -16'(D2_LIMIT);
    end else begin
      d2_next = d2_sum[15:0];
    end
  end

  // Final product, rescaled by one more bit for the halving, and saturated.
  always_comb begin
    m10 = wide_t'(s9_g) * wide_t'(s9_d2);
    r_w = round_shift(m10, FRAC_BITS + 1);
    if (r_w > wide_t'({1'b0, {(DATA_WIDTH-1){1'b1}}})) begin
      r_next = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else if (r_w < -wide_t'({1'b1, {(DATA_WIDTH-1){1'b0}}})) begin
      r_next = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      r_next = r_w[DATA_WIDTH-1:0];
    end
  end

  // Data registers, each loaded when its stage advances.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_x  <= din.activation_input;
      s0_g  <= din.upstream_gradient;
      s0_x2 <= x2_next;
    end
    if (en[1]) begin
      s1_x   <= s0_x;
      s1_g   <= s0_g;
      s1_kx2 <= kx2_next;
    end
    if (en[2]) begin
      s2_x   <= s1_x;
      s2_g   <= s1_g;
      s2_kx2 <= s1_kx2;
      s2_p   <= p_next;
    end
    if (en[3]) begin
      s3_x   <= s2_x;
      s3_g   <= s2_g;
      s3_kx2 <= s2_kx2;
      s3_u   <= u_next;
    end
    if (en[4]) begin
      s4_x   <= s3_x;
      s4_g   <= s3_g;
      s4_kx2 <= s3_kx2;
      s4_t   <= t_next;
    end
    if (en[5]) begin
      s5_x <= s4_x;
      s5_g <= s4_g;
      s5_f <= f_next;
      s5_t <= s4_t;
      s5_s <= s_next;
    end
    if (en[6]) begin
      s6_g <= s5_g;
      s6_f <= s5_f;
      s6_t <= s5_t;
      s6_a <= a_next;
    end
    if (en[7]) begin
      s7_g <= s6_g;
      s7_f <= s6_f;
      s7_t <= s6_t;
      s7_b <= b_next;
    end
    if (en[8]) begin
      s8_g <= s7_g;
      s8_t <= s7_t;
      s8_c <= c_next;
    end
    if (en[9]) begin
      s9_g  <= s8_g;
      s9_d2 <= d2_next;
    end
    if (en[10]) begin
      s10_r <= r_next;
    end
  end

  // An empty output register never holds back the input side.
  assert property (@(posedge clk) disable iff (rst) !dout.valid |-> din.ready)
    else $error("Input stalled while the output register is empty.");

  // An accepted word always occupies the first stage on the next cycle.
  assert property (@(posedge clk) disable iff (rst) din.valid && din.ready |=> vld[0])
    else $error("Accepted word did not enter the pipeline.");

  // Tanh never leaves the closed interval from minus one to one.
  assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (s4_t <= 14'(ONE) && s4_t >= -14'(ONE)))
    else $error("Tanh value out of range.");

  // One minus t squared stays between zero and one.
  assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (s5_s >= 0 && s5_s <= 14'(ONE)))
    else $error("Derivative term 1 - t^2 out of range.");

  // Stage 9, when full and blocked, keeps its valid bit.
  assert property (@(posedge clk) disable iff (rst)
    vld[9] && !en[9] |=> vld[9])
    else $error("Held pipeline word was dropped.");

endmodule
